// ===== rtl/wctema_pkg.sv =====
// ----------------------------------------------------------------------------
// wctema_pkg
// Types and constants shared by the windowed contact-time average block.
// ----------------------------------------------------------------------------
`default_nettype none
package wctema_pkg;

  localparam logic [1:0] REQ_UP   = 2'd0;
  localparam logic [1:0] REQ_DOWN = 2'd1;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_ALPHA  = 1'b1;

  localparam logic [23:0] DUR_MAX       = 24'hFFFFFF;
  localparam logic [23:0] WINDOW_RESET  = 24'd1000;
  localparam logic [16:0] ALPHA_RESET   = 17'd32768;
  localparam logic [16:0] ALPHA_ONE     = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_KCALC,
    ST_XREAD,
    ST_XMUL,
    ST_XSUM,
    ST_XWRITE,
    ST_AREAD,
    ST_AWRITE,
    ST_FINAL,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/windowed_contact_time_ema.sv =====
// ----------------------------------------------------------------------------
// windowed_contact_time_ema
// Per-peer contact time over windows, blended into an exponential average.
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata: req_type, peer_id, timestamp
// m_axis    out  tvalid/tready    tdata: familiarity; tuser: time_error
// cfg       in   cfg_we           cfg_index, cfg_data
//
// after reset a clearing pass over all NUM_PEERS entries runs before the first beat.
// an event runs one accrual sweep over all peers.
// crossing one or more boundaries adds a k count and one blend sweep over all
// peers, plus one more blend step per repeated window of a peer until
// its average stops changing.
// a result waits in the output register while the next beat is taken; the
// block stalls in its last state until that register is free.
`default_nettype none
module windowed_contact_time_ema #(
  parameter int NUM_PEERS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,  // req_type[1:0], peer_id[7:2], timestamp[39:8]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // familiarity[31:0]
  output logic        m_axis_tuser,  // time_error
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [23:0] cfg_data
);

  localparam int AW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_PEERS - 1);

  // memory: {open 8, dur 24, avg 32}
  logic [63:0] mem [NUM_PEERS];
  logic [63:0] rd;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  wctema_pkg::state_t state, state_next;

  logic [23:0] window_ticks;
  logic [16:0] alpha_q16;
  logic [31:0] last_time;
  logic [32:0] next_boundary;
  logic [1:0]  req;
  logic [5:0]  peer;
  logic [31:0] ts;
  logic [AW-1:0] idx;
  logic [32:0] k;        // boundaries still to repeat (k-1)
  logic [32:0] kj;       // per-peer repeat counter
  logic [32:0] rem;
  logic [5:0]  dcnt;
  logic [32:0] elapsed;
  logic [31:0] fam;
  logic [23:0] dsel;
  logic [47:0] p1, p2;
  logic [7:0]  cur_open;
  logic [31:0] result;
  logic        res_err;
  logic        err;
  logic        ovalid;

  logic [23:0] weff;
  logic [16:0] aeff;
  logic [16:0] ainv;
  assign weff = (window_ticks == 24'd0) ? 24'd1 : window_ticks;
  assign aeff = (alpha_q16 > wctema_pkg::ALPHA_ONE) ? wctema_pkg::ALPHA_ONE : alpha_q16;
  assign ainv = wctema_pkg::ALPHA_ONE - aeff;

  logic [32:0] diff;
  assign diff = {1'b0, ts} - next_boundary;
  logic [33:0] rem_sh;
  assign rem_sh = {rem, diff[32 - dcnt[5:0] +: 1]};

  logic [31:0] blended;
  logic [48:0] bsum;
  assign bsum = {1'b0, p1} + {1'b0, p2};
  assign blended = bsum[47:16];

  logic [24:0] acc;
  assign acc = {1'b0, rd[55:32]} + ((elapsed > 33'(wctema_pkg::DUR_MAX)) ?
               25'(wctema_pkg::DUR_MAX) : elapsed[24:0]);
  logic [23:0] accd;
  assign accd = (rd[63:56] != 8'd0) ?
                ((acc > 25'(wctema_pkg::DUR_MAX)) ? wctema_pkg::DUR_MAX : acc[23:0]) :
                rd[55:32];

  logic pvalid;
  assign pvalid = (7'(peer) < 7'(NUM_PEERS)) || (NUM_PEERS >= 64);
  logic [AW-1:0] paddr;
  assign paddr = AW'(peer);
  logic lastidx;
  assign lastidx = (idx == LAST);
  // output register free at this edge
  logic oadv;
  assign oadv = !ovalid || m_axis_tready;

  assign s_axis_tready = (state == wctema_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = result;
  assign m_axis_tuser  = res_err;

  always_comb begin
    state_next = state;
    unique case (state)
      wctema_pkg::ST_IDLE:   if (s_axis_tvalid && s_axis_tready)
                               state_next = wctema_pkg::ST_CHECK;
      wctema_pkg::ST_CLEAR:  if (lastidx) state_next = wctema_pkg::ST_IDLE;
      wctema_pkg::ST_CHECK:
        if (ts < last_time) state_next = wctema_pkg::ST_FINAL;
        else if ({1'b0, ts} >= next_boundary) state_next = wctema_pkg::ST_KCALC;
        else state_next = wctema_pkg::ST_AREAD;
      wctema_pkg::ST_KCALC:  if (dcnt == 6'd33) state_next = wctema_pkg::ST_XREAD;
      wctema_pkg::ST_XREAD:  state_next = wctema_pkg::ST_XMUL;
      wctema_pkg::ST_XMUL:   state_next = wctema_pkg::ST_XSUM;
      wctema_pkg::ST_XSUM:
        if (kj == 33'd0 || (blended == fam && kj != k)) state_next = wctema_pkg::ST_XWRITE;
        else state_next = wctema_pkg::ST_XMUL;
      wctema_pkg::ST_XWRITE: state_next = lastidx ? wctema_pkg::ST_AREAD
                                                  : wctema_pkg::ST_XREAD;
      wctema_pkg::ST_AREAD:  state_next = wctema_pkg::ST_AWRITE;
      wctema_pkg::ST_AWRITE: state_next = lastidx ? wctema_pkg::ST_FINAL
                                                  : wctema_pkg::ST_AREAD;
      wctema_pkg::ST_FINAL:  state_next = wctema_pkg::ST_OUT;
      wctema_pkg::ST_OUT:    if (oadv) state_next = wctema_pkg::ST_IDLE;
      default:               state_next = wctema_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    raddr = idx;
    wdata = rd;
    unique case (state)
      wctema_pkg::ST_CLEAR: begin
        we = 1'b1;
        wdata = '0;
      end
      wctema_pkg::ST_XWRITE: begin
        we = 1'b1;
        wdata = {cur_open, 24'd0, fam};
      end
      wctema_pkg::ST_AWRITE: begin
        we = 1'b1;
        wdata = {rd[63:56], accd, rd[31:0]};
      end
      wctema_pkg::ST_FINAL: raddr = paddr;
      wctema_pkg::ST_OUT: begin
        raddr = paddr;
        waddr = paddr;
        we = oadv && pvalid && !err &&
             ((req == wctema_pkg::REQ_UP && rd[63:56] != 8'hFF) ||
              (req == wctema_pkg::REQ_DOWN && rd[63:56] != 8'h00));
        wdata = {(req == wctema_pkg::REQ_UP) ? rd[63:56] + 8'd1 : rd[63:56] - 8'd1,
                 rd[55:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wctema_pkg::ST_CLEAR;
      idx <= '0;
      ovalid <= 1'b0;
      window_ticks <= wctema_pkg::WINDOW_RESET;
      alpha_q16 <= wctema_pkg::ALPHA_RESET;
      last_time <= '0;
      next_boundary <= 33'(wctema_pkg::WINDOW_RESET);
    end else begin
      state <= state_next;
      if (ovalid && m_axis_tready) ovalid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == wctema_pkg::REG_WINDOW) begin
          window_ticks <= cfg_data;
          next_boundary <= {1'b0, last_time} +
                           33'((cfg_data == 24'd0) ? 24'd1 : cfg_data);
        end else begin
          alpha_q16 <= {1'b0, cfg_data[15:0]} | {cfg_data[16], 16'd0};
        end
      end
      unique case (state)
        wctema_pkg::ST_IDLE: begin
          idx <= '0;
          if (s_axis_tvalid && s_axis_tready) begin
            req  <= s_axis_tdata[1:0];
            peer <= s_axis_tdata[7:2];
            ts   <= s_axis_tdata[39:8];
          end
        end
        wctema_pkg::ST_CLEAR: idx <= idx + 1'b1;
        wctema_pkg::ST_CHECK: begin
          err  <= (ts < last_time);
          rem  <= '0;
          k    <= '0;
          dcnt <= '0;
          elapsed <= {1'b0, ts} - {1'b0, last_time};
        end
        wctema_pkg::ST_KCALC: begin
          if (dcnt != 6'd33) begin
            if (rem_sh >= {10'd0, weff}) begin
              rem <= 33'(rem_sh - {10'd0, weff});
              k   <= {k[31:0], 1'b1};
            end else begin
              rem <= rem_sh[32:0];
              k   <= {k[31:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
          end else begin
            // accrue up to the first boundary during the blend sweep
            elapsed <= next_boundary - {1'b0, last_time};
          end
        end
        wctema_pkg::ST_XREAD: ;
        wctema_pkg::ST_XMUL: begin
          if (kj == k) begin
            cur_open <= rd[63:56];
            p1 <= 48'(aeff) * 48'({accd, 8'd0});
            fam <= rd[31:0];
            p2 <= 48'(ainv) * 48'(rd[31:0]);
          end else begin
            p1 <= 48'(aeff) * 48'({dsel, 8'd0});
            p2 <= 48'(ainv) * 48'(fam);
          end
        end
        wctema_pkg::ST_XSUM: begin
          fam <= blended;
          kj <= (kj == 33'd0) ? 33'd0 : kj - 33'd1;
          if (blended == fam && kj != k) fam <= fam;
        end
        wctema_pkg::ST_XWRITE: begin
          idx <= lastidx ? '0 : idx + 1'b1;
          if (lastidx) begin
            // last crossed boundary sits the remainder of the k count below ts
            last_time <= ts - rem[31:0];
            elapsed <= rem;
            next_boundary <= {1'b0, ts - rem[31:0]} + {9'd0, weff};
          end
        end
        wctema_pkg::ST_AREAD: ;
        wctema_pkg::ST_AWRITE: begin
          idx <= lastidx ? '0 : idx + 1'b1;
          if (lastidx) last_time <= ts;
        end
        wctema_pkg::ST_FINAL: ;
        wctema_pkg::ST_OUT: begin
          if (oadv) begin
            result <= pvalid ? rd[31:0] : 32'd0;
            res_err <= err;
            ovalid <= 1'b1;
          end
        end
        default: ;
      endcase
      if (state == wctema_pkg::ST_XREAD) kj <= k;
    end
  end

  assign dsel = (cur_open != 8'd0) ? weff : 24'd0;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser)) else $error("result changed while stalled");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == wctema_pkg::ST_OUT))
    else $error("result outside out state");
  a_time_fwd: assert property (@(posedge clk) disable iff (rst)
    (state != wctema_pkg::ST_IDLE && !cfg_we) |=> next_boundary > {1'b0, last_time}
    || state == wctema_pkg::ST_XWRITE) else $error("boundary behind time");
`endif

endmodule
`default_nettype wire

// ===== test/tb_windowed_contact_time_ema.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_contact_time_ema
// Self-checking bench for the windowed contact-time average block. A queued
// driver sends timestamped contact events. A clocked monitor predicts each
// peer's familiarity and checks every result beat against it. Runs go
// through several window and alpha settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_windowed_contact_time_ema;

  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int NPEER = 64;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] fam;
    logic        err;
  } fam_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // req_type[1:0], peer_id[7:2], timestamp[39:8]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // familiarity[31:0]
  logic        m_axis_tuser;   // time_error
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_data;

  windowed_contact_time_ema dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predicted block state
  logic [7:0]  contacts [NPEER];
  logic [23:0] win_dur [NPEER];
  logic [31:0] fam_avg [NPEER];
  logic [31:0] last_t;
  longint unsigned next_bnd;
  logic [23:0] win_reg;
  logic [16:0] alpha_reg;

  logic [39:0]  event_q [$];
  fam_result_t  fam_q [$];
  int errors;
  int in_beats;
  int out_beats;
  int err_beats;
  int drv_seen;
  int src_gap;
  int sink_stall;
  bit quiet;
  int idle_cycles;
  longint unsigned stim_t;

  function automatic longint unsigned eff_window();
    return (win_reg == 24'd0) ? 64'd1 : 64'(win_reg);
  endfunction

  function automatic logic [31:0] blend(logic [31:0] f, logic [23:0] d);
    longint unsigned a;
    longint unsigned s;
    a = (alpha_reg > wctema_pkg::ALPHA_ONE) ? 64'd65536 : 64'(alpha_reg);
    s = a * (64'(d) << 8) + (64'd65536 - a) * 64'(f);
    return s[47:16];
  endfunction

  task automatic accrue(longint unsigned elapsed);
    longint unsigned d;
    for (int i = 0; i < NPEER; i++) begin
      if (contacts[i] != 8'd0) begin
        d = 64'(win_dur[i]) + elapsed;
        win_dur[i] = (d > 64'(wctema_pkg::DUR_MAX)) ? wctema_pkg::DUR_MAX : d[23:0];
      end
    end
  endtask

  task automatic cross_windows(longint unsigned k);
    longint unsigned w;
    logic [31:0] f;
    logic [31:0] g;
    logic [23:0] d;
    w = eff_window();
    accrue(next_bnd - 64'(last_t));
    for (int i = 0; i < NPEER; i++) begin
      f = blend(fam_avg[i], win_dur[i]);
      d = (contacts[i] != 8'd0) ? w[23:0] : 24'd0;
      // stop once a full window no longer moves the average
      for (longint unsigned j = 1; j < k; j++) begin
        g = blend(f, d);
        if (g == f) break;
        f = g;
      end
      fam_avg[i] = f;
      win_dur[i] = 24'd0;
    end
    last_t = 32'(next_bnd + (k - 1) * w);
    next_bnd = next_bnd + k * w;
  endtask

  task automatic predict_event(logic [39:0] beat);
    logic [1:0]  req;
    logic [5:0]  peer;
    logic [31:0] t;
    fam_result_t r;
    req = beat[1:0];
    peer = beat[7:2];
    t = beat[39:8];
    if (t < last_t) begin
      r.fam = fam_avg[peer];
      r.err = 1'b1;
    end else begin
      if (64'(t) >= next_bnd)
        cross_windows((64'(t) - next_bnd) / eff_window() + 1);
      accrue(64'(t) - 64'(last_t));
      last_t = t;
      if (req == wctema_pkg::REQ_UP && contacts[peer] != 8'hFF) contacts[peer]++;
      else if (req == wctema_pkg::REQ_DOWN && contacts[peer] != 8'h00) contacts[peer]--;
      r.fam = fam_avg[peer];
      r.err = 1'b0;
    end
    fam_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, out_beats);
    errors++;
  endtask

  // monitor: input beats feed the predictor, output beats are checked
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_event(s_axis_tdata);
        void'(event_q.pop_front());
        in_beats++;
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (fam_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, 32'd0);
        end else begin
          if (m_axis_tdata !== fam_q[0].fam)
            report_mismatch("familiarity", m_axis_tdata, fam_q[0].fam);
          if (m_axis_tuser !== fam_q[0].err)
            report_mismatch("time_error", 32'(m_axis_tuser), 32'(fam_q[0].err));
          if (fam_q[0].err) err_beats++;
          void'(fam_q.pop_front());
        end
        out_beats++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // source driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_beats != drv_seen) begin
        drv_seen = in_beats;
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (event_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tdata <= event_q[0];
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // sink stalls
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        sink_stall = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_event(logic [1:0] req, logic [5:0] peer, logic [31:0] t);
    event_q.push_back({t, peer, req});
  endtask

  task automatic drain();
    while (event_q.size() != 0 || fam_q.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == wctema_pkg::REG_WINDOW) begin
      win_reg = val;
      next_bnd = 64'(last_t) + eff_window();
    end else begin
      alpha_reg = val[16:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_events(int n, longint unsigned max_delta);
    logic [1:0] req;
    logic [5:0] peer;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      req = (r < 4) ? wctema_pkg::REQ_UP : (r < 7) ? wctema_pkg::REQ_DOWN :
            (r < 9) ? REQ_QUERY : REQ_SPARE;
      peer = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, 7));
      if ($urandom_range(0, 19) == 0) begin
        push_event(req, peer, 32'($urandom_range(0, 32'(stim_t))));
      end else begin
        if ($urandom_range(0, 9) != 0)
          stim_t = stim_t + $urandom_range(0, 32'(max_delta));
        push_event(req, peer, 32'(stim_t));
      end
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = wctema_pkg::REG_WINDOW;
    cfg_data = '0;
    errors = 0;
    in_beats = 0;
    out_beats = 0;
    err_beats = 0;
    drv_seen = 0;
    src_gap = 0;
    sink_stall = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    for (int i = 0; i < NPEER; i++) begin
      contacts[i] = '0;
      win_dur[i] = '0;
      fam_avg[i] = '0;
    end
    last_t = '0;
    win_reg = wctema_pkg::WINDOW_RESET;
    alpha_reg = wctema_pkg::ALPHA_RESET;
    next_bnd = 64'(wctema_pkg::WINDOW_RESET);
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, exact boundary, going backwards, count floor
    push_event(wctema_pkg::REQ_UP, 6'd0, 32'd0);
    push_event(wctema_pkg::REQ_UP, 6'd63, 32'd5);
    push_event(REQ_QUERY, 6'd63, 32'd999);
    push_event(REQ_QUERY, 6'd0, 32'd1000);
    push_event(wctema_pkg::REQ_DOWN, 6'd0, 32'd1500);
    push_event(wctema_pkg::REQ_DOWN, 6'd0, 32'd1600);
    push_event(REQ_SPARE, 6'd63, 32'd2500);
    push_event(REQ_QUERY, 6'd63, 32'd100);
    push_event(wctema_pkg::REQ_UP, 6'd1, 32'd2600);
    push_event(REQ_QUERY, 6'd1, 32'd5000);
    push_event(wctema_pkg::REQ_UP, 6'd42, 32'd5000);
    push_event(REQ_QUERY, 6'd21, 32'd7999);
    push_event(wctema_pkg::REQ_DOWN, 6'd63, 32'd8000);
    stim_t = 8000;
    drain();

    write_reg(wctema_pkg::REG_WINDOW, 24'd1);
    write_reg(wctema_pkg::REG_ALPHA, 24'd65536);
    random_events(120, 4);
    drain();

    write_reg(wctema_pkg::REG_WINDOW, 24'd0);
    write_reg(wctema_pkg::REG_ALPHA, 24'd0);
    random_events(120, 3);
    drain();

    write_reg(wctema_pkg::REG_WINDOW, 24'hFFFFFF);
    write_reg(wctema_pkg::REG_ALPHA, 24'h01FFFF);
    random_events(120, 64'd4194304);
    drain();

    write_reg(wctema_pkg::REG_WINDOW, 24'd1000);
    write_reg(wctema_pkg::REG_ALPHA, 24'd1);
    random_events(120, 3000);
    drain();

    // push one peer's open count into both saturation limits
    write_reg(wctema_pkg::REG_WINDOW, 24'd5000);
    write_reg(wctema_pkg::REG_ALPHA, 24'd40000);
    for (int i = 0; i < 260; i++) begin
      stim_t = stim_t + $urandom_range(0, 40);
      push_event(wctema_pkg::REQ_UP, 6'd7, 32'(stim_t));
    end
    for (int i = 0; i < 262; i++) begin
      stim_t = stim_t + $urandom_range(0, 40);
      push_event(wctema_pkg::REQ_DOWN, 6'd7, 32'(stim_t));
    end
    random_events(60, 8000);
    drain();

    // no idling from here on, then a jump to the top of the time range
    quiet = 1'b1;
    write_reg(wctema_pkg::REG_WINDOW, 24'd777);
    write_reg(wctema_pkg::REG_ALPHA, 24'd65536);
    random_events(100, 2000);
    push_event(wctema_pkg::REQ_UP, 6'd3, 32'hFFFFFF00);
    push_event(REQ_QUERY, 6'd3, 32'hFFFFFFF0);
    push_event(REQ_QUERY, 6'd7, 32'h7FFFFFFF);
    push_event(wctema_pkg::REQ_DOWN, 6'd3, 32'hFFFFFFFF);
    push_event(REQ_QUERY, 6'd3, 32'hFFFFFFFF);
    drain();
    repeat (1000) @(posedge clk);

    $display("sent %0d events, checked %0d results (%0d with time error)",
             in_beats, out_beats, err_beats);
    $display("covered seven window/alpha settings incl. zero and clamped values");
    if (errors == 0 && fam_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
